@@ hdl/ptt_pkg.sv @@
`timescale 1ns / 1ps

package ptt_pkg;

	// geometry of the translated space
	localparam int PAGE_COUNT  = 64;
	localparam int FRAME_COUNT = 16;
	localparam int OFFSET_BITS = 12;

	localparam int DATA_W   = 32;
	localparam int VADDR_W  = 32;
	localparam int INDEX_W  = 20;
	localparam int VPN_W    = VADDR_W - OFFSET_BITS;
	localparam int PAGE_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int FRAME_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int OFF_W    = OFFSET_BITS - 2;
	localparam int WORD_W   = FRAME_W + OFF_W;
	localparam int WORD_COUNT = FRAME_COUNT << OFF_W;

	typedef enum logic [1:0] {
		ACT_MAP   = 2'd0,
		ACT_READ  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_NONE  = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_PAGE_RANGE  = 2'd1,
		ST_UNMAPPED    = 2'd2,
		ST_FRAME_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_SPARE = 2'd3
	} op_t;

	// one classified command handed from the front to the back
	typedef struct packed {
		op_t                op;
		logic [WORD_W-1:0]  addr;
		logic [DATA_W-1:0]  wdata;
		status_t            status;
	} ptt_cmd_t;

endpackage

@@ hdl/ptt_front.sv @@
`timescale 1ns / 1ps

module ptt_front import ptt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mem_ready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [VADDR_W-1:0]  virtual_address,
	input  logic [INDEX_W-1:0]  page_index,
	input  logic [INDEX_W-1:0]  frame_index,
	input  logic [DATA_W-1:0]   write_data,
	output logic                push,
	output ptt_cmd_t            cmd,
	input  logic                q_full
);

	logic [FRAME_W-1:0]  pt_frame_mem [PAGE_COUNT];
	logic [PAGE_COUNT-1:0] page_valid_q;

	logic                accept;
	act_t                act_in;
	logic [VPN_W-1:0]    vpn;
	logic                map_ok;
	status_t             map_st;

	logic                valid_s1;
	act_t                act_s1;
	status_t             map_st_s1;
	logic                page_bad_s1;
	logic                pvalid_s1;
	logic [FRAME_W-1:0]  pframe_s1;
	logic [OFF_W-1:0]    off_s1;
	logic [DATA_W-1:0]   wdata_s1;

	assign act_in = act_t'(action);
	assign vpn    = virtual_address[VADDR_W-1:OFFSET_BITS];

	assign push     = valid_s1 && !q_full;
	assign in_ready = mem_ready && (!valid_s1 || push);
	assign accept   = in_valid && in_ready;

	// map checks the page before the frame
	always_comb begin
		map_st = ST_OK;
		if (32'(page_index) >= 32'(PAGE_COUNT)) begin
			map_st = ST_PAGE_RANGE;
		end else if (32'(frame_index) >= 32'(FRAME_COUNT)) begin
			map_st = ST_FRAME_RANGE;
		end
	end
	assign map_ok = (act_in == ACT_MAP) && (map_st == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			page_valid_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
			if (accept && map_ok) begin
				page_valid_q[page_index[PAGE_W-1:0]] <= 1'b1;
			end
		end
	end

	// page table: frame store plus lookup for the accepted address
	always_ff @(posedge clk) begin
		if (accept && map_ok) begin
			pt_frame_mem[page_index[PAGE_W-1:0]] <= frame_index[FRAME_W-1:0];
		end
		if (accept) begin
			pframe_s1   <= pt_frame_mem[vpn[PAGE_W-1:0]];
			pvalid_s1   <= page_valid_q[vpn[PAGE_W-1:0]];
			page_bad_s1 <= 32'(vpn) >= 32'(PAGE_COUNT);
			act_s1      <= act_in;
			map_st_s1   <= map_st;
			off_s1      <= virtual_address[OFFSET_BITS-1:2];
			wdata_s1    <= write_data;
		end
	end

	// classify the held transaction
	always_comb begin
		status_t acc_st;
		acc_st = ST_OK;
		if (page_bad_s1) begin
			acc_st = ST_PAGE_RANGE;
		end else if (!pvalid_s1) begin
			acc_st = ST_UNMAPPED;
		end else if (32'(pframe_s1) >= 32'(FRAME_COUNT)) begin
			acc_st = ST_FRAME_RANGE;
		end
		cmd.addr  = {pframe_s1, off_s1};
		cmd.wdata = wdata_s1;
		unique case (act_s1)
			ACT_MAP: begin
				cmd.op     = OP_NONE;
				cmd.status = map_st_s1;
			end
			ACT_READ: begin
				cmd.op     = (acc_st == ST_OK) ? OP_READ : OP_NONE;
				cmd.status = acc_st;
			end
			ACT_WRITE: begin
				cmd.op     = (acc_st == ST_OK) ? OP_WRITE : OP_NONE;
				cmd.status = acc_st;
			end
			default: begin
				cmd.op     = OP_NONE;
				cmd.status = ST_OK;
			end
		endcase
	end

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> mem_ready) else $error("transaction taken during memory clear");
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !push |=> valid_s1) else $error("stalled front stage lost");

endmodule

@@ hdl/ptt_queue.sv @@
`timescale 1ns / 1ps

module ptt_queue import ptt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ptt_cmd_t  cmd_in,
	output logic      full,
	input  logic      pop,
	output ptt_cmd_t  cmd_out,
	output logic      empty
);

	ptt_cmd_t    entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign cmd_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue underflow");

endmodule

@@ hdl/ptt_back.sv @@
`timescale 1ns / 1ps

module ptt_back import ptt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	output logic               mem_ready,
	input  ptt_cmd_t           cmd,
	input  logic               q_empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DATA_W-1:0]  read_data,
	output logic [1:0]         status
);

	typedef enum logic [1:0] {
		B_CLEAR = 2'b01,
		B_RUN   = 2'b10
	} back_state_t;

	back_state_t         state_q;
	back_state_t         state_d;
	logic [WORD_W-1:0]   clr_addr_q;
	logic                clr_last;

	logic [DATA_W-1:0]   phys_mem [WORD_COUNT];
	logic [DATA_W-1:0]   rdata_q;
	logic                out_valid_q;
	logic                is_read_q;
	status_t             status_q;

	assign mem_ready = state_q == B_RUN;
	assign clr_last  = clr_addr_q == WORD_W'(WORD_COUNT - 1);
	assign pop       = mem_ready && !q_empty && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR: if (clr_last) state_d = B_RUN;
			B_RUN:   state_d = B_RUN;
			default: state_d = B_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_addr_q <= clr_addr_q + WORD_W'(1);
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// physical word store, one access per cycle
	always_ff @(posedge clk) begin
		if (state_q == B_CLEAR) begin
			phys_mem[clr_addr_q] <= '0;
		end else if (pop && cmd.op == OP_WRITE) begin
			phys_mem[cmd.addr] <= cmd.wdata;
		end
		if (pop) begin
			rdata_q   <= phys_mem[cmd.addr];
			is_read_q <= cmd.op == OP_READ;
			status_q  <= cmd.status;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = is_read_q ? rdata_q : '0;
	assign status    = status_q;

	a_pop_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == B_RUN) else $error("memory access during clear");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(status_q))
		else $error("pending result dropped");

endmodule

@@ hdl/page_table_translating_memory_core.sv @@
// the result passes the lookup register, the queue and the memory read register in that order
// throughput: one transaction per cycle while the result side keeps taking results
// the page table lookup and the single port of the physical word memory set that rate
// after reset the physical memory is cleared one word a cycle, all 16384 words, with in_ready low
// reset clears all page mappings and the queue; results appear strictly in order
`timescale 1ns / 1ps

module page_table_translating_memory_core import ptt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [VADDR_W-1:0]  virtual_address,
	input  logic [INDEX_W-1:0]  page_index,
	input  logic [INDEX_W-1:0]  frame_index,
	input  logic [DATA_W-1:0]   write_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DATA_W-1:0]   read_data,
	output logic [1:0]          status
);

	// front to back command path
	ptt_cmd_t  front_cmd;
	ptt_cmd_t  back_cmd;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;
	// high once the physical memory clear has finished
	logic      mem_ready;

	// front: takes transactions, updates and looks up the page table, classifies errors
	ptt_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.mem_ready       (mem_ready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.virtual_address (virtual_address),
		.page_index      (page_index),
		.frame_index     (frame_index),
		.write_data      (write_data),
		.push            (push),
		.cmd             (front_cmd),
		.q_full          (q_full)
	);

	// two-entry queue so front and back stall independently
	ptt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (front_cmd),
		.full    (q_full),
		.pop     (pop),
		.cmd_out (back_cmd),
		.empty   (q_empty)
	);

	// back: memory clear after reset, word read or write, result register
	ptt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_ready (mem_ready),
		.cmd       (back_cmd),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data),
		.status    (status)
	);

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import ptt_pkg::*;

	// one expected result: the word read and the status code
	typedef struct packed {
		logic [DATA_W-1:0] data;
		status_t           st;
	} reply_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          action;
	logic [VADDR_W-1:0]  virtual_address;
	logic [INDEX_W-1:0]  page_index;
	logic [INDEX_W-1:0]  frame_index;
	logic [DATA_W-1:0]   write_data;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [DATA_W-1:0]   read_data;
	logic [1:0]          status;

	// shadow copy of the page table and the physical memory
	logic                shadow_valid [PAGE_COUNT];
	logic [FRAME_W-1:0]  shadow_frame [PAGE_COUNT];
	logic [DATA_W-1:0]   shadow_words [WORD_COUNT];

	// replies owed by the block, oldest first
	reply_t pending_replies [$];

	int mismatches = 0;
	bit no_idle = 1'b0;

	page_table_translating_memory_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.virtual_address (virtual_address),
		.page_index      (page_index),
		.frame_index     (frame_index),
		.write_data      (write_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.read_data       (read_data),
		.status          (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs or the clearing pass never ends
	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// apply one request to the shadow state and work out the reply it owes
	function automatic reply_t translate_request(act_t act, logic [VADDR_W-1:0] va,
			logic [INDEX_W-1:0] pg, logic [INDEX_W-1:0] fr, logic [DATA_W-1:0] wd);
		reply_t             r;
		logic [VPN_W-1:0]   vpn;
		logic [WORD_W-1:0]  widx;
		r.data = '0;
		r.st   = ST_OK;
		vpn    = va[VADDR_W-1:OFFSET_BITS];
		case (act)
			ACT_MAP: begin
				// page is checked ahead of the frame, table untouched on error
				if (pg >= PAGE_COUNT)
					r.st = ST_PAGE_RANGE;
				else if (fr >= FRAME_COUNT)
					r.st = ST_FRAME_RANGE;
				else begin
					shadow_frame[pg[PAGE_W-1:0]] = fr[FRAME_W-1:0];
					shadow_valid[pg[PAGE_W-1:0]] = 1'b1;
				end
			end
			ACT_READ, ACT_WRITE: begin
				// stored frames are always in range, so only two lookup errors remain
				if (vpn >= PAGE_COUNT)
					r.st = ST_PAGE_RANGE;
				else if (!shadow_valid[vpn[PAGE_W-1:0]])
					r.st = ST_UNMAPPED;
				else begin
					widx = {shadow_frame[vpn[PAGE_W-1:0]], va[OFFSET_BITS-1:2]};
					if (act == ACT_READ)
						r.data = shadow_words[widx];
					else
						shadow_words[widx] = wd;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// predict on each accepted request, then check each accepted result;
	// one block so a same-edge push always lands ahead of the pop
	always @(posedge clk) begin : monitor
		reply_t want;
		if (in_valid && in_ready)
			pending_replies.push_back(translate_request(act_t'(action), virtual_address,
				page_index, frame_index, write_data));
		if (out_valid && out_ready) begin
			if (pending_replies.size() == 0)
				report_mismatch("result with no request pending", read_data, '0);
			else begin
				want = pending_replies.pop_front();
				if (read_data !== want.data)
					report_mismatch("read_data", read_data, want.data);
				if (status !== want.st)
					report_mismatch("status", {30'd0, status}, {30'd0, want.st});
			end
		end
	end

	// result side backpressure, off during the no-idle stretch
	always @(negedge clk)
		out_ready <= no_idle || ($urandom_range(99) >= 26);

	// entered at a falling edge, returns at the falling edge after acceptance
	// with valid still high so back-to-back transactions need no extra step
	task automatic send_request(act_t act, logic [VADDR_W-1:0] va, logic [INDEX_W-1:0] pg,
			logic [INDEX_W-1:0] fr, logic [DATA_W-1:0] wd);
		while (!no_idle && $urandom_range(99) < 26) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		action          = act;
		virtual_address = va;
		page_index      = pg;
		frame_index     = fr;
		write_data      = wd;
		in_valid        = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold the request side until every owed reply has come back
	task automatic wait_for_drain();
		in_valid = 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// mostly a handful of low pages so mapped accesses are common
	function automatic logic [INDEX_W-1:0] pick_page();
		if ($urandom_range(9) < 8)
			return INDEX_W'($urandom_range(15));
		return INDEX_W'($urandom_range(PAGE_COUNT - 1));
	endfunction

	// filler for index fields that the action ignores
	function automatic logic [INDEX_W-1:0] rand_index();
		return INDEX_W'($urandom());
	endfunction

	// accesses before any map: unmapped and out of range pages
	task automatic test_empty_table();
		send_request(ACT_READ, 32'h0000_0000, rand_index(), rand_index(), $urandom());
		send_request(ACT_WRITE, 32'hFFFF_FFFF, rand_index(), rand_index(), 32'hFFFF_FFFF);
		send_request(ACT_READ, 32'h0004_0000, rand_index(), rand_index(), $urandom());
		send_request(ACT_WRITE, 32'h0003_F000, rand_index(), rand_index(), 32'h1234_5678);
	endtask

	// map requests rejected by the page or the frame check
	task automatic test_map_errors();
		send_request(ACT_MAP, $urandom(), 20'hFFFFF, 20'h00000, $urandom());
		send_request(ACT_MAP, $urandom(), 20'd64, 20'hFFFFF, $urandom());
		send_request(ACT_MAP, $urandom(), 20'd0, 20'd16, $urandom());
		send_request(ACT_MAP, $urandom(), 20'd0, 20'hFFFFF, $urandom());
		// page 0 must still read as unmapped
		send_request(ACT_READ, 32'h0000_0000, rand_index(), rand_index(), $urandom());
	endtask

	// lowest and highest page and frame, words at both ends of memory
	task automatic test_map_and_access();
		send_request(ACT_MAP, $urandom(), 20'd0, 20'd0, $urandom());
		send_request(ACT_MAP, $urandom(), 20'd63, 20'd15, $urandom());
		send_request(ACT_READ, 32'h0000_0000, rand_index(), rand_index(), $urandom());
		send_request(ACT_WRITE, 32'h0000_0000, rand_index(), rand_index(), 32'hFFFF_FFFF);
		send_request(ACT_WRITE, 32'h0003_FFFF, rand_index(), rand_index(), 32'hA5A5_A5A5);
		send_request(ACT_READ, 32'h0000_0003, rand_index(), rand_index(), $urandom());
		send_request(ACT_READ, 32'h0003_FFFC, rand_index(), rand_index(), $urandom());
	endtask

	// remap onto another frame, then back; reads follow the table
	task automatic test_remap();
		wait_for_drain();
		send_request(ACT_MAP, $urandom(), 20'd63, 20'd0, $urandom());
		send_request(ACT_READ, 32'h0003_F000, rand_index(), rand_index(), $urandom());
		send_request(ACT_MAP, $urandom(), 20'd63, 20'd15, $urandom());
		send_request(ACT_READ, 32'h0003_FFFD, rand_index(), rand_index(), $urandom());
	endtask

	// spare action code leaves table and memory alone
	task automatic test_unused_action();
		send_request(ACT_NONE, 32'h0000_0000, 20'd1, 20'd1, 32'h0000_0000);
		send_request(ACT_NONE, 32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
		send_request(ACT_READ, 32'h0000_0000, rand_index(), rand_index(), $urandom());
		send_request(ACT_READ, 32'h0000_1000, rand_index(), rand_index(), $urandom());
	endtask

	// mixed traffic: maps, writes, reads of recently written words, noise
	task automatic test_random_traffic(int count);
		int                  r;
		logic [VADDR_W-1:0]  va;
		logic [INDEX_W-1:0]  pg;
		logic [INDEX_W-1:0]  fr;
		logic [DATA_W-1:0]   wd;
		logic [VADDR_W-1:0]  recent [$];
		for (int n = 0; n < count; n++) begin
			no_idle = (n >= 300 && n < 500);
			if (n == 650)
				wait_for_drain();
			r  = $urandom_range(99);
			va = $urandom();
			pg = INDEX_W'($urandom());
			fr = INDEX_W'($urandom());
			wd = $urandom();
			if (r < 12) begin
				send_request(ACT_MAP, va, pick_page(), INDEX_W'($urandom_range(FRAME_COUNT - 1)), wd);
			end else if (r < 15) begin
				// bad page or bad frame
				if ($urandom_range(1))
					send_request(ACT_MAP, va, pg, fr, wd);
				else
					send_request(ACT_MAP, va, pick_page(),
						INDEX_W'(FRAME_COUNT + $urandom_range(20'hFFFFF - FRAME_COUNT)), wd);
			end else if (r < 50) begin
				va = {pick_page(), va[OFFSET_BITS-1:0]};
				recent.push_back(va);
				if (recent.size() > 64)
					void'(recent.pop_front());
				send_request(ACT_WRITE, va, pg, fr, wd);
			end else if (r < 88) begin
				if (recent.size() != 0 && $urandom_range(9) < 6) begin
					va = recent[$urandom_range(recent.size() - 1)];
					va[1:0] = 2'($urandom_range(3));
				end else
					va = {pick_page(), va[OFFSET_BITS-1:0]};
				send_request(ACT_READ, va, pg, fr, wd);
			end else if (r < 92) begin
				send_request(ACT_NONE, va, pg, fr, wd);
			end else begin
				// raw noise: any action, any address
				send_request(act_t'($urandom_range(3)), va, pg, fr, wd);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		action          = ACT_NONE;
		virtual_address = '0;
		page_index      = '0;
		frame_index     = '0;
		write_data      = '0;
		for (int p = 0; p < PAGE_COUNT; p++) begin
			shadow_valid[p] = 1'b0;
			shadow_frame[p] = '0;
		end
		for (int w = 0; w < WORD_COUNT; w++)
			shadow_words[w] = '0;

		// single reset at the start; the block then clears its memory on its own
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_map_errors();
		test_map_and_access();
		test_remap();
		test_unused_action();
		test_random_traffic(900);

		// let every owed reply come back, then report the verdict
		wait_for_drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/ptt_pkg.sv
hdl/ptt_front.sv
hdl/ptt_queue.sv
hdl/ptt_back.sv
hdl/page_table_translating_memory_core.sv
sim/testbench.sv
